// File: design/mi3_pkg.sv
// shared widths, constants and index tables for the 3x3 matrix inverse
// no dependencies
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int AW        = PROD_W + 1;
  localparam int AMW       = PROD_W;
  localparam int LO_W      = 33;
  localparam int HI_W      = AW - LO_W;
  localparam int DW        = AW + DATA_W + 2;
  localparam int DMW       = DW - 1;
  localparam int RW        = (AMW + 2 * FRAC_BITS + 2 > DMW + 34) ?
                             AMW + 2 * FRAC_BITS + 2 : DMW + 34;
  localparam int QW        = DATA_W;
  localparam int NENT      = 9;

  localparam logic [3:0] ADJ_P [NENT][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

// File: design/mi3_if.sv
// request channels of the 3x3 matrix inverse: input matrix and result
// depends on mi3_pkg
interface mi3_mat_if;
  logic valid;
  logic ready;
  logic signed [mi3_pkg::DATA_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source(output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink(input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface mi3_inv_if;
  logic valid;
  logic ready;
  logic signed [mi3_pkg::DATA_W-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic signed [mi3_pkg::DATA_W-1:0] determinant;
  logic singular;
  logic overflow;
  modport source(output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                 determinant, singular, overflow, input ready);
  modport sink(input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
               determinant, singular, overflow, output ready);
endinterface

// File: design/matrix3x3_inverse_top.sv
// 3x3 matrix inverse by adjugate and determinant, pipelined restoring divide
// depends on mi3_pkg and the channel interfaces in mi3_if
// pipeline: 41 register stages from the input to the result register
// throughput: one request per cycle while inv.ready is high or no result is held; the 32 divide stages and the
//   multiplier stages all advance together under one pipeline enable
// reset: rst clears every stage valid bit; payload registers are not reset
module matrix3x3_inverse_top (
  input logic clk,
  input logic rst,
  mi3_mat_if.sink   mat,
  mi3_inv_if.source inv
);
  import mi3_pkg::*;

  logic adv;
  logic signed [DATA_W-1:0] ain [NENT];

  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [PROD_W-1:0] p1 [2*NENT];
  logic signed [DATA_W-1:0] r1 [3];
  logic signed [DATA_W-1:0] r2 [3];
  logic signed [AW-1:0] adj2 [NENT];
  logic signed [AW-1:0] adj3 [NENT];
  logic signed [AW-1:0] adj4 [NENT];
  logic signed [AW-1:0] adj5 [NENT];
  logic signed [DATA_W+LO_W:0] pl3 [3];
  logic signed [DATA_W+HI_W-1:0] ph3 [3];
  logic signed [DW-1:0] term4 [3];
  logic signed [DW-1:0] det5;
  logic [DMW-1:0] dmag6;
  logic dneg6, sing6;
  logic [AMW-1:0] am6 [NENT];
  logic [NENT-1:0] sn6;
  logic [RW-1:0] num7 [NENT];
  logic [RW-1:0] den7;
  logic [NENT-1:0] sn7;
  logic sing7, dov7;
  logic [DATA_W-1:0] dfld7;
  logic [DMW:0] rd6;

  logic dval [QW+1];
  logic [RW-1:0] rem [QW+1][NENT];
  logic [QW-1:0] quo [QW+1][NENT];
  logic [RW-1:0] dden [QW+1];
  logic [NENT-1:0] dsn [QW+1];
  logic [NENT-1:0] dpov [QW+1];
  logic [DATA_W-1:0] ddet [QW+1];
  logic ddov [QW+1];
  logic dsing [QW+1];
  logic [RW:0] trial [QW][NENT];

  logic vout;
  logic [DATA_W-1:0] bout [NENT];
  logic [DATA_W-1:0] detout;
  logic singout, ovfout;
  logic [DATA_W-1:0] bsat [NENT];
  logic [NENT-1:0] bov;

  assign adv = !vout || inv.ready;
  assign mat.ready = adv;

  assign ain[0] = mat.a00;
  assign ain[1] = mat.a01;
  assign ain[2] = mat.a02;
  assign ain[3] = mat.a10;
  assign ain[4] = mat.a11;
  assign ain[5] = mat.a12;
  assign ain[6] = mat.a20;
  assign ain[7] = mat.a21;
  assign ain[8] = mat.a22;

  // determinant rounding
  assign rd6 = ({1'b0, dmag6} + ((DMW+1)'(1) << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < NENT; i++) begin
        trial[k][i] = {1'b0, rem[k][i]} - {1'b0, dden[k] << (QW-1-k)};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NENT; i++) begin
      if (dpov[QW][i]) begin
        bov[i] = 1'b1;
        bsat[i] = dsn[QW][i] ? NEG_MIN : POS_MAX;
      end else if (!dsn[QW][i]) begin
        bov[i] = quo[QW][i] > POS_MAX;
        bsat[i] = bov[i] ? POS_MAX : quo[QW][i];
      end else begin
        bov[i] = quo[QW][i] > NEG_MIN;
        bsat[i] = bov[i] ? NEG_MIN : (~quo[QW][i] + DATA_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      for (int k = 0; k <= QW; k++) dval[k] <= 1'b0;
      vout <= 1'b0;
    end else if (adv) begin
      v1 <= mat.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      dval[0] <= v7;
      for (int k = 0; k < QW; k++) dval[k+1] <= dval[k];
      vout <= dval[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // cofactor products
      for (int i = 0; i < NENT; i++) begin
        p1[2*i]   <= ain[ADJ_P[i][0]] * ain[ADJ_P[i][1]];
        p1[2*i+1] <= ain[ADJ_P[i][2]] * ain[ADJ_P[i][3]];
      end
      for (int j = 0; j < 3; j++) r1[j] <= ain[j];
      // adjugate
      for (int i = 0; i < NENT; i++) adj2[i] <= AW'(p1[2*i]) - AW'(p1[2*i+1]);
      r2 <= r1;
      // row 0 expansion, split products
      for (int j = 0; j < 3; j++) begin
        pl3[j] <= r2[j] * $signed({1'b0, adj2[3*j][LO_W-1:0]});
        ph3[j] <= r2[j] * $signed(adj2[3*j][AW-1:LO_W]);
      end
      adj3 <= adj2;
      for (int j = 0; j < 3; j++) term4[j] <= (DW'(ph3[j]) <<< LO_W) + DW'(pl3[j]);
      adj4 <= adj3;
      det5 <= term4[0] + term4[1] + term4[2];
      adj5 <= adj4;
      // magnitudes and signs
      dneg6 <= det5[DW-1];
      dmag6 <= det5[DW-1] ? DMW'(-det5) : DMW'(det5);
      sing6 <= det5 == '0;
      for (int i = 0; i < NENT; i++) begin
        am6[i] <= adj5[i][AW-1] ? AMW'(-adj5[i]) : AMW'(adj5[i]);
        sn6[i] <= adj5[i][AW-1] ^ det5[DW-1];
      end
      // determinant field, dividend and divisor
      if (!dneg6) begin
        dov7  <= rd6 > (DMW+1)'(POS_MAX);
        dfld7 <= (rd6 > (DMW+1)'(POS_MAX)) ? POS_MAX : rd6[DATA_W-1:0];
      end else begin
        dov7  <= rd6 > (DMW+1)'(NEG_MIN);
        dfld7 <= (rd6 > (DMW+1)'(NEG_MIN)) ? NEG_MIN : (~rd6[DATA_W-1:0] + DATA_W'(1));
      end
      for (int i = 0; i < NENT; i++) begin
        num7[i] <= (RW'(am6[i]) << (2*FRAC_BITS+1)) + RW'(dmag6);
      end
      den7  <= RW'(dmag6) << 1;
      sn7   <= sn6;
      sing7 <= sing6;
      // divide entry, quotient range check
      for (int i = 0; i < NENT; i++) begin
        rem[0][i]  <= num7[i];
        quo[0][i]  <= '0;
        dpov[0][i] <= num7[i] >= (den7 << QW);
      end
      dden[0]  <= den7;
      dsn[0]   <= sn7;
      ddet[0]  <= dfld7;
      ddov[0]  <= dov7;
      dsing[0] <= sing7;
      // one quotient bit per stage
      for (int k = 0; k < QW; k++) begin
        for (int i = 0; i < NENT; i++) begin
          if (!trial[k][i][RW]) begin
            rem[k+1][i] <= trial[k][i][RW-1:0];
            quo[k+1][i] <= quo[k][i] | (QW'(1) << (QW-1-k));
          end else begin
            rem[k+1][i] <= rem[k][i];
            quo[k+1][i] <= quo[k][i];
          end
        end
        dden[k+1]  <= dden[k];
        dsn[k+1]   <= dsn[k];
        dpov[k+1]  <= dpov[k];
        ddet[k+1]  <= ddet[k];
        ddov[k+1]  <= ddov[k];
        dsing[k+1] <= dsing[k];
      end
      // saturation and singular override
      for (int i = 0; i < NENT; i++) bout[i] <= dsing[QW] ? '0 : bsat[i];
      detout  <= ddet[QW];
      singout <= dsing[QW];
      ovfout  <= ddov[QW] || (!dsing[QW] && (|bov));
    end
  end

  assign inv.valid       = vout;
  assign inv.b00         = bout[0];
  assign inv.b01         = bout[1];
  assign inv.b02         = bout[2];
  assign inv.b10         = bout[3];
  assign inv.b11         = bout[4];
  assign inv.b12         = bout[5];
  assign inv.b20         = bout[6];
  assign inv.b21         = bout[7];
  assign inv.b22         = bout[8];
  assign inv.determinant = detout;
  assign inv.singular    = singout;
  assign inv.overflow    = ovfout;

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    inv.valid && inv.singular |-> inv.determinant == '0 && !inv.overflow && inv.b11 == '0)
    else $error("singular result not cleared");
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !inv.valid)
    else $error("result valid right after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    mat.ready == (!inv.valid || inv.ready))
    else $error("pipeline enable mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dval[0]) && $stable(v1))
    else $error("stage moved while stalled");

endmodule
